// File: sv/sfpsd_pkg.sv
package sfpsd_pkg;

    // operation codes carried in tuser
    typedef enum logic [1:0] {
        OP_WRITE    = 2'd0,
        OP_READ     = 2'd1,
        OP_SET_AXIS = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    // frame type, bits 9-8 of a written frame
    typedef enum logic [1:0] {
        FRAME_NULL  = 2'd0,
        FRAME_CTRL  = 2'd1,
        FRAME_DATA  = 2'd2,
        FRAME_SPARE = 2'd3
    } frame_kind_t;

    // configuration register indexes
    localparam logic CFG_CHIP_VARIANT = 1'b0;
    localparam logic CFG_AXIS_SELECT  = 1'b1;

    localparam int TDATA_W  = 32;
    localparam int AXIS_W   = 11;

    // read modes, bits 7-6 of the control byte
    localparam logic [1:0] MODE_ID  = 2'b01;
    localparam logic [1:0] MODE_ADC = 2'b11;

    // select-ID handshake
    localparam logic [7:0] SELECT_ID_CODE  = 8'h43;
    localparam logic [7:0] SELECT_ID_REPLY = 8'h80;

    // newer map register selects
    localparam logic [3:0] NEW_SEL_ADC    = 4'h0;
    localparam logic [3:0] NEW_SEL_RAIL   = 4'h1;
    localparam logic [3:0] NEW_SEL_ANALOG = 4'h3;
    localparam logic [3:0] NEW_SEL_ADCCTL = 4'h7;
    localparam logic [3:0] NEW_SEL_STATUS = 4'hD;

    // older map register selects
    localparam logic [3:0] OLD_SEL_RAIL   = 4'h0;
    localparam logic [3:0] OLD_SEL_ANALOG = 4'h1;

    localparam logic [7:0] NEW_STATUS_BYTE = 8'h02;
    localparam logic [7:0] OLD_STATUS_BASE = 8'h40;
    localparam logic [7:0] OLD_STATUS_FULL = 8'h07;
    localparam logic [7:0] ADC_SIGN_FLIP   = 8'h80;
    localparam logic [AXIS_W-1:0] BATTERY_LEVEL = 11'h7FF;

    // adc channel codes of the newer map
    localparam logic [1:0] ADC_CH_TOUCH = 2'd0;
    localparam logic [1:0] ADC_CH_ZERO  = 2'd1;

    // one input transaction, unpacked
    typedef struct packed {
        op_t         op;
        logic [9:0]  frame;
        logic [1:0]  axis_index;
        logic [15:0] axis_value;
    } item_t;

    // configuration write port
    typedef struct packed {
        logic we;
        logic index;
        logic data;
    } cfg_write_t;

endpackage

// File: sv/sfpsd_core.sv
module sfpsd_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sfpsd_pkg::cfg_write_t cfg,
    input  logic                 item_go,
    input  sfpsd_pkg::item_t     item,
    output logic [7:0]           read_data
);
    import sfpsd_pkg::*;

    logic              chip_variant_reg;
    logic              axis_select_reg;
    logic [7:0]        control_byte_reg;
    logic [7:0]        rail_control_reg;
    logic [7:0]        analog_control_reg;
    logic [7:0]        adc_control_reg;
    logic [AXIS_W-1:0] touch_axes_reg [2];

    logic [3:0]        sel;
    frame_kind_t       kind;
    logic [7:0]        byte_in;
    logic [1:0]        new_ch;
    logic              old_full;
    logic [AXIS_W-1:0] adc_value;

    assign sel     = control_byte_reg[3:0];
    assign kind    = frame_kind_t'(item.frame[9:8]);
    assign byte_in = item.frame[7:0];

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chip_variant_reg <= 1'b0;
            axis_select_reg  <= 1'b0;
        end else if (cfg.we) begin
            unique case (cfg.index)
                CFG_CHIP_VARIANT: chip_variant_reg <= cfg.data;
                CFG_AXIS_SELECT:  axis_select_reg  <= cfg.data;
                default: ;
            endcase
        end
    end

    // bus state: null, control and data frames
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            control_byte_reg   <= '0;
            rail_control_reg   <= '0;
            analog_control_reg <= '0;
            adc_control_reg    <= '0;
        end else if (item_go && item.op == OP_WRITE) begin
            unique case (kind)
                FRAME_NULL: begin
                    control_byte_reg   <= '0;
                    rail_control_reg   <= '0;
                    analog_control_reg <= '0;
                    adc_control_reg    <= '0;
                end
                FRAME_CTRL: control_byte_reg <= byte_in;
                FRAME_DATA: begin
                    if (chip_variant_reg) begin
                        unique case (sel)
                            NEW_SEL_RAIL:   rail_control_reg   <= byte_in;
                            NEW_SEL_ANALOG: analog_control_reg <= byte_in;
                            NEW_SEL_ADCCTL: adc_control_reg    <= byte_in;
                            default: ;
                        endcase
                    end else begin
                        unique case (sel)
                            OLD_SEL_RAIL:   rail_control_reg   <= byte_in;
                            OLD_SEL_ANALOG: analog_control_reg <= byte_in;
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    // touch axes, kept across null frames
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            touch_axes_reg[0] <= '0;
            touch_axes_reg[1] <= '0;
        end else if (item_go && item.op == OP_SET_AXIS && !item.axis_index[1]) begin
            touch_axes_reg[item.axis_index[0]] <= item.axis_value[AXIS_W-1:0];
        end
    end

    // adc source selection
    assign new_ch   = analog_control_reg[7:6];
    assign old_full = analog_control_reg[5];

    always_comb begin
        case (new_ch)
            ADC_CH_TOUCH: adc_value = touch_axes_reg[axis_select_reg];
            ADC_CH_ZERO:  adc_value = '0;
            default:      adc_value = BATTERY_LEVEL;
        endcase
    end

    // read multiplexer
    always_comb begin
        read_data = '0;
        if (item.op == OP_READ) begin
            if (control_byte_reg[7:6] == MODE_ID) begin
                read_data = (control_byte_reg == SELECT_ID_CODE) ? SELECT_ID_REPLY : 8'h00;
            end else if (control_byte_reg[7:6] == MODE_ADC) begin
                if (chip_variant_reg) begin
                    unique case (sel)
                        NEW_SEL_ADC: begin
                            if (adc_control_reg[2])
                                read_data = {5'b0, adc_value[10:8]};
                            else
                                read_data = adc_value[7:0] ^ ADC_SIGN_FLIP;
                        end
                        NEW_SEL_STATUS: read_data = NEW_STATUS_BYTE;
                        default:        read_data = '0;
                    endcase
                end else begin
                    unique case (sel)
                        OLD_SEL_RAIL:   read_data = old_full ? 8'hFF : 8'h00;
                        OLD_SEL_ANALOG: read_data = OLD_STATUS_BASE
                                                  | (old_full ? OLD_STATUS_FULL : 8'h00);
                        default:        read_data = '0;
                    endcase
                end
            end
        end
    end

endmodule

// File: sv/serial_frame_power_supply_device.sv
// Power-supply peripheral on a 10-bit serial frame bus. Each input transaction
// (tuser = operation) is a frame write, a read or a touch-axis update, and
// gives exactly one result byte, which is zero for anything but a read. An
// item is held in the input register, then decoded and applied to the register
// file on its way into the result register, so the block takes one transaction
// per cycle when the output is not stalled. Configuration (chip variant, touch
// axis for ADC channel zero) is written through cfg_we/cfg_index/cfg_data; the
// user must write it only while idle, as the block itself does not enforce this.
module serial_frame_power_supply_device (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic                            cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // frame [9:0], axis_index [11:10], axis_value [27:12], zero [31:28]
    input  logic [sfpsd_pkg::TDATA_W-1:0]   s_tdata,
    // operation [1:0]
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // read_data [7:0]
    output logic [7:0]                      m_tdata
);
    import sfpsd_pkg::*;

    logic       in_valid_reg;
    item_t      in_item_reg;
    logic       out_valid_reg;
    logic [7:0] out_data_reg;
    logic       out_free;
    logic       advance;
    logic [7:0] result;
    cfg_write_t cfg;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;

    assign cfg = '{we: cfg_we, index: cfg_index, data: cfg_data};

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.op         <= op_t'(s_tuser);
            in_item_reg.frame      <= s_tdata[9:0];
            in_item_reg.axis_index <= s_tdata[11:10];
            in_item_reg.axis_value <= s_tdata[27:12];
        end
    end

    sfpsd_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .item_go   (advance),
        .item      (in_item_reg),
        .read_data (result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: sv/sfpsd_checker.sv
module sfpsd_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [1:0]                    s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [7:0]                    m_tdata
);
    import sfpsd_pkg::*;

    // no result straight after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // input only stalls behind a stalled, full output
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output back-pressure");

    // a non-read transaction returns zero through the input and result registers when the sink is ready
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser != OP_READ) ##1 m_tready
        |=> m_tvalid && m_tdata == 8'h00)
        else $error("non-read transaction gave non-zero data");

endmodule

bind serial_frame_power_supply_device sfpsd_checker u_sfpsd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
